### design/lcal_pkg.sv
// Shared constants, codes and control types of the lowest-common-ancestor engine.
package lcal_pkg;

  localparam int NODE_W     = 10;
  localparam int NODES      = 1 << NODE_W;
  localparam int LEVELS     = 10;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int DEP_W      = 10;
  localparam int CNT_W      = 10;
  localparam int ACT_W      = 2;
  localparam int ANC_DEPTH  = LEVELS * NODES;
  localparam int ANC_AW     = LVL_W + NODE_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [ACT_W-1:0] ACT_LOAD  = ACT_W'(0);
  localparam logic [ACT_W-1:0] ACT_BUILD = ACT_W'(1);
  localparam logic [ACT_W-1:0] ACT_QUERY = ACT_W'(2);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_READ,
    OP_SWAP,
    OP_LIFT,
    OP_JOIN0,
    OP_JOIN,
    OP_PAR,
    OP_RESULT,
    OP_B_INIT,
    OP_B_RUN,
    OP_B_NEXT
  } dp_op_e;

  typedef struct packed {
    logic k_zero;
    logic k_last;
    logic ab_eq;
    logic drained;
  } dp_sts_t;

endpackage

### design/lowest_common_ancestor_lifting_top.sv
// Query: depth lift, then joint lift and parent step unless the depth-aligned nodes match.
// The lift and the joint lift each walk the levels top down on the dual-read ancestor RAM.
// Load writes one parent and depth. Build fills levels 1..LEVELS-1, one table entry a cycle.
// A new request is taken once the previous one is done, even while a result waits.
// Reset (async, active low) clears control state; table contents stay undefined until loaded.
module lowest_common_ancestor_lifting_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [9:0] node_a, [19:10] node_b, [29:20] node_depth, [31:30] zero
  input  logic [lcal_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] action
  input  logic [lcal_pkg::ACT_W-1:0]     s_axis_tuser,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [9:0] ancestor, [15:10] zero
  output logic [lcal_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lcal_pkg::CNT_W-1:0]     cfg_data_i
);

  localparam int NW = lcal_pkg::NODE_W;
  localparam int DW = lcal_pkg::DEP_W;

  lcal_pkg::dp_op_e  op;
  lcal_pkg::dp_sts_t sts;
  logic [NW-1:0]     res_ancestor;

  assign cfg_ready_o = 1'b1;

  lcal_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .action_i (s_axis_tuser),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .sts_i    (sts),
    .op_o     (op)
  );

  lcal_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .sts_o         (sts),
    .in_node_a_i   (s_axis_tdata[NW-1:0]),
    .in_node_b_i   (s_axis_tdata[2*NW-1:NW]),
    .in_depth_i    (s_axis_tdata[2*NW+DW-1:2*NW]),
    .in_final_i    (s_axis_tlast),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .res_ancestor_o(res_ancestor),
    .res_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {(lcal_pkg::OUT_DATA_W - NW)'(0), res_ancestor};

endmodule

### design/lcal_ram.sv
// Generic RAM: one write port, two registered read ports.
module lcal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/lcal_dp.sv
// Datapath: ancestor and depth tables, node registers, build pipeline, result register.
module lcal_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcal_pkg::dp_op_e            op_i,
  output lcal_pkg::dp_sts_t           sts_o,
  input  logic [lcal_pkg::NODE_W-1:0] in_node_a_i,
  input  logic [lcal_pkg::NODE_W-1:0] in_node_b_i,
  input  logic [lcal_pkg::DEP_W-1:0]  in_depth_i,
  input  logic                        in_final_i,
  input  logic                        cfg_we_i,
  input  logic [lcal_pkg::CNT_W-1:0]  cfg_data_i,
  output logic [lcal_pkg::NODE_W-1:0] res_ancestor_o,
  output logic                        res_last_o
);

  localparam int NW = lcal_pkg::NODE_W;
  localparam int LW = lcal_pkg::LVL_W;
  localparam int DW = lcal_pkg::DEP_W;
  localparam int IW = lcal_pkg::NODE_W + 1;
  localparam logic [LW-1:0] LVL_TOP = LW'(lcal_pkg::LEVELS - 1);

  logic [lcal_pkg::CNT_W-1:0] node_count_q;
  logic [NW-1:0] a_q, a_d, b_q, b_d;
  logic [DW-1:0] dep_in_q, dep_in_d;
  logic          fin_q, fin_d;
  logic [lcal_pkg::LEVELS-1:0] dif_q, dif_d;
  logic [LW-1:0] k_q, k_d, k_next;
  logic [IW-1:0] i_q, i_d;
  logic [NW-1:0] top_q, top_d;
  logic          p1_v_q, p1_v_d, p2_v_q, p2_v_d;
  logic [NW-1:0] p1_i_q, p1_i_d, p2_i_q, p2_i_d;
  logic          za_q, zb_q;
  logic [NW-1:0] res_q, res_d;
  logic          res_last_q, res_last_d;

  logic [LW-1:0] rd_lvl;
  logic [NW-1:0] rd_node_a, rd_node_b;
  logic          anc_we, dep_we;
  logic [lcal_pkg::ANC_AW-1:0] anc_waddr;
  logic [NW-1:0] anc_wdata;
  logic [NW-1:0] anc_rd_a, anc_rd_b, anc_a, anc_b;
  logic [DW-1:0] dep_rd_a, dep_rd_b, dep_a, dep_b;
  logic [DW-1:0] dep_diff;
  logic          iss;

  lcal_ram #(
    .WIDTH(NW),
    .DEPTH(lcal_pkg::ANC_DEPTH)
  ) u_anc_ram (
    .clk_i    (clk_i),
    .we_i     (anc_we),
    .waddr_i  (anc_waddr),
    .wdata_i  (anc_wdata),
    .raddr_a_i({rd_lvl, rd_node_a}),
    .raddr_b_i({rd_lvl, rd_node_b}),
    .rdata_a_o(anc_rd_a),
    .rdata_b_o(anc_rd_b)
  );

  lcal_ram #(
    .WIDTH(DW),
    .DEPTH(lcal_pkg::NODES)
  ) u_dep_ram (
    .clk_i    (clk_i),
    .we_i     (dep_we),
    .waddr_i  (a_q),
    .wdata_i  (dep_in_q),
    .raddr_a_i(rd_node_a),
    .raddr_b_i(rd_node_b),
    .rdata_a_o(dep_rd_a),
    .rdata_b_o(dep_rd_b)
  );

  // Node 0 reads as zero in both tables.
  assign anc_a  = za_q ? '0 : anc_rd_a;
  assign anc_b  = zb_q ? '0 : anc_rd_b;
  assign dep_a  = za_q ? '0 : dep_rd_a;
  assign dep_b  = zb_q ? '0 : dep_rd_b;
  assign k_next = (k_q == '0) ? '0 : k_q - 1'b1;
  assign iss    = (i_q <= {1'b0, top_q});

  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    dep_in_d   = dep_in_q;
    fin_d      = fin_q;
    dif_d      = dif_q;
    k_d        = k_q;
    i_d        = i_q;
    top_d      = top_q;
    p1_v_d     = p1_v_q;
    p2_v_d     = p2_v_q;
    p1_i_d     = p1_i_q;
    p2_i_d     = p2_i_q;
    res_d      = res_q;
    res_last_d = res_last_q;
    rd_lvl     = k_q;
    rd_node_a  = a_q;
    rd_node_b  = b_q;
    anc_we     = 1'b0;
    anc_waddr  = {k_q, p2_i_q};
    anc_wdata  = anc_b;
    dep_we     = 1'b0;
    dep_diff   = '0;
    case (op_i)
      lcal_pkg::OP_ACCEPT: begin
        a_d      = in_node_a_i;
        b_d      = in_node_b_i;
        dep_in_d = in_depth_i;
        fin_d    = in_final_i;
        top_d    = node_count_q;
      end
      lcal_pkg::OP_LOAD: begin
        // node 0 keeps its zero row
        anc_we    = (a_q != '0);
        dep_we    = (a_q != '0);
        anc_waddr = {LW'(0), a_q};
        anc_wdata = b_q;
      end
      lcal_pkg::OP_READ: begin
      end
      lcal_pkg::OP_SWAP: begin
        if (dep_a < dep_b) begin
          a_d      = b_q;
          b_d      = a_q;
          dep_diff = dep_b - dep_a;
        end else begin
          dep_diff = dep_a - dep_b;
        end
        dif_d = dep_diff[lcal_pkg::LEVELS-1:0];
        k_d   = LVL_TOP;
      end
      lcal_pkg::OP_LIFT: begin
        if (dif_q[k_q]) begin
          a_d = anc_a;
        end
        k_d       = k_next;
        rd_lvl    = k_next;
        rd_node_a = a_d;
      end
      lcal_pkg::OP_JOIN0: begin
        k_d    = LVL_TOP;
        rd_lvl = LVL_TOP;
      end
      lcal_pkg::OP_JOIN: begin
        // lift both while the ancestors differ and stay below the root
        if (anc_a != '0 && anc_a != anc_b) begin
          a_d = anc_a;
          b_d = anc_b;
        end
        k_d       = k_next;
        rd_lvl    = k_next;
        rd_node_a = a_d;
        rd_node_b = b_d;
      end
      lcal_pkg::OP_PAR: begin
        if (anc_a != '0) begin
          a_d = anc_a;
        end
      end
      lcal_pkg::OP_RESULT: begin
        res_d      = a_q;
        res_last_d = fin_q;
      end
      lcal_pkg::OP_B_INIT: begin
        k_d    = LW'(1);
        i_d    = IW'(1);
        p1_v_d = 1'b0;
        p2_v_d = 1'b0;
      end
      lcal_pkg::OP_B_RUN: begin
        // stage 1 reads the row entry, stage 2 reads its ancestor, then write
        rd_lvl    = k_q - 1'b1;
        rd_node_a = i_q[NW-1:0];
        rd_node_b = anc_a;
        p1_v_d    = iss;
        p1_i_d    = i_q[NW-1:0];
        p2_v_d    = p1_v_q;
        p2_i_d    = p1_i_q;
        i_d       = i_q + IW'(iss);
        anc_we    = p2_v_q;
        anc_waddr = {k_q, p2_i_q};
        anc_wdata = anc_b;
      end
      lcal_pkg::OP_B_NEXT: begin
        k_d = k_q + 1'b1;
        i_d = IW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= lcal_pkg::CNT_W'(1);
      p1_v_q       <= 1'b0;
      p2_v_q       <= 1'b0;
      k_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
      p1_v_q <= p1_v_d;
      p2_v_q <= p2_v_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q        <= a_d;
    b_q        <= b_d;
    dep_in_q   <= dep_in_d;
    fin_q      <= fin_d;
    dif_q      <= dif_d;
    i_q        <= i_d;
    top_q      <= top_d;
    p1_i_q     <= p1_i_d;
    p2_i_q     <= p2_i_d;
    za_q       <= (rd_node_a == '0);
    zb_q       <= (rd_node_b == '0);
    res_q      <= res_d;
    res_last_q <= res_last_d;
  end

  assign sts_o.k_zero  = (k_q == '0);
  assign sts_o.k_last  = (k_q == LVL_TOP);
  assign sts_o.ab_eq   = (a_q == b_q);
  assign sts_o.drained = !iss && !p1_v_q && !p2_v_q;

  assign res_ancestor_o = res_q;
  assign res_last_o     = res_last_q;

endmodule

### design/lcal_ctrl.sv
// Controller: sequences load, build and query requests and owns the result valid flag.
module lcal_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [lcal_pkg::ACT_W-1:0] action_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  input  lcal_pkg::dp_sts_t          sts_i,
  output lcal_pkg::dp_op_e           op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_QDEP,
    S_QSWAP,
    S_QLIFT0,
    S_QLIFT,
    S_QJOIN0,
    S_QJOIN,
    S_QPAR,
    S_QOUT,
    S_BINIT,
    S_BRUN
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d   = state_q;
    op_o      = lcal_pkg::OP_NONE;
    m_valid_d = m_valid_q && !m_ready_i;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          op_o = lcal_pkg::OP_ACCEPT;
          case (action_i)
            lcal_pkg::ACT_LOAD:  state_d = S_LOAD;
            lcal_pkg::ACT_BUILD: state_d = S_BINIT;
            lcal_pkg::ACT_QUERY: state_d = S_QDEP;
            default:             state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        op_o    = lcal_pkg::OP_LOAD;
        state_d = S_IDLE;
      end
      S_QDEP: begin
        op_o    = lcal_pkg::OP_READ;
        state_d = S_QSWAP;
      end
      S_QSWAP: begin
        op_o    = lcal_pkg::OP_SWAP;
        state_d = S_QLIFT0;
      end
      S_QLIFT0: begin
        op_o    = lcal_pkg::OP_READ;
        state_d = S_QLIFT;
      end
      S_QLIFT: begin
        op_o = lcal_pkg::OP_LIFT;
        if (sts_i.k_zero) begin
          state_d = S_QJOIN0;
        end
      end
      S_QJOIN0: begin
        if (sts_i.ab_eq) begin
          state_d = S_QOUT;
        end else begin
          op_o    = lcal_pkg::OP_JOIN0;
          state_d = S_QJOIN;
        end
      end
      S_QJOIN: begin
        op_o = lcal_pkg::OP_JOIN;
        if (sts_i.k_zero) begin
          state_d = S_QPAR;
        end
      end
      S_QPAR: begin
        op_o    = lcal_pkg::OP_PAR;
        state_d = S_QOUT;
      end
      S_QOUT: begin
        // hold until the result register is free or being drained
        if (!m_valid_q || m_ready_i) begin
          op_o      = lcal_pkg::OP_RESULT;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_BINIT: begin
        op_o    = lcal_pkg::OP_B_INIT;
        state_d = S_BRUN;
      end
      S_BRUN: begin
        if (!sts_i.drained) begin
          op_o = lcal_pkg::OP_B_RUN;
        end else if (sts_i.k_last) begin
          state_d = S_IDLE;
        end else begin
          op_o = lcal_pkg::OP_B_NEXT;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

### design/lcal_checker.sv
// Port-level checker for the lowest-common-ancestor engine, bound to the top level.
module lcal_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [lcal_pkg::ACT_W-1:0]      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [lcal_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  logic in_take;

  assign in_take = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && s_axis_tuser == lcal_pkg::ACT_QUERY |=> !s_axis_tready)
    else $error("request taken while a query is in progress");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && s_axis_tuser != lcal_pkg::ACT_QUERY && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result raised by a request that is not a query");

endmodule

bind lowest_common_ancestor_lifting_top lcal_checker u_lcal_checker (.*);

### tb/tb_lowest_common_ancestor_lifting_top.sv
// Self-checking testbench for the binary-lifting lowest-common-ancestor engine.
`timescale 1ns / 100ps

module tb_lowest_common_ancestor_lifting_top;
  import lcal_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = ACT_W'(3);
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MIX_ITEMS   = 60;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [DEP_W-1:0]  depth;
    logic              fin;
  } lca_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              last;
  } lca_ans_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [ACT_W-1:0]      s_axis_tuser = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CNT_W-1:0]      cfg_data_i = '0;

  lowest_common_ancestor_lifting_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the engine: parent tables, depths and the node_count register.
  logic [NODE_W-1:0] anc_mem [NODES][LEVELS];
  logic [DEP_W-1:0]  dep_mem [NODES];
  logic [CNT_W-1:0]  node_limit = CNT_W'(1);

  lca_req_t req_q[$];
  lca_ans_t lca_q[$];
  lca_req_t cur_req;
  lca_ans_t want;

  // Stimulus bookkeeping: nodes 1..built_upto have every level written.
  logic [DEP_W-1:0] gen_depth [NODES];
  logic             gen_loaded [NODES];
  int               gen_count = 1;
  int               loaded_upto = 0;
  int               built_upto = 0;

  bit calm = 1'b0;
  int send_gap = 0;
  int rcv_stall = 0;
  int errors = 0;
  int cycle_cnt = 0;
  int n_loads = 0, n_builds = 0, n_queries = 0, n_ignored = 0, n_answers = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void build_levels(input logic [CNT_W-1:0] top);
    for (int k = 1; k < LEVELS; k++)
      for (int i = 1; i <= int'(top); i++)
        anc_mem[i][k] = anc_mem[anc_mem[i][k-1]][k-1];
  endfunction

  function automatic logic [NODE_W-1:0] lca_of(input logic [NODE_W-1:0] na,
                                               input logic [NODE_W-1:0] nb);
    logic [NODE_W-1:0] a, b, pa, pb;
    logic [DEP_W-1:0]  dif;
    a = na;
    b = nb;
    if (dep_mem[a] < dep_mem[b]) begin
      a = nb;
      b = na;
    end
    dif = dep_mem[a] - dep_mem[b];
    for (int k = LEVELS - 1; k >= 0; k--)
      if (dif[k]) a = anc_mem[a][k];
    if (a != b) begin
      // joint lift; an ancestor of 0 means past the root, so skip it
      for (int k = LEVELS - 1; k >= 0; k--) begin
        pa = anc_mem[a][k];
        pb = anc_mem[b][k];
        if (pa != '0 && pa != pb) begin
          a = pa;
          b = pb;
        end
      end
      if (anc_mem[a][0] != '0) a = anc_mem[a][0];
    end
    return a;
  endfunction

  function automatic void apply_request(input lca_req_t req);
    lca_ans_t ans;
    case (req.action)
      ACT_LOAD: begin
        if (req.node_a != '0) begin
          anc_mem[req.node_a][0] = req.node_b;
          dep_mem[req.node_a] = req.depth;
        end
        n_loads++;
      end
      ACT_BUILD: begin
        build_levels(node_limit);
        n_builds++;
      end
      ACT_QUERY: begin
        ans.ancestor = lca_of(req.node_a, req.node_b);
        ans.last     = req.fin;
        lca_q.insert(lca_q.size(), ans);
        n_queries++;
      end
      default: n_ignored++;
    endcase
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(cur_req);
        send_gap = calm ? 0 : pick_gap();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          cur_req = req_q.pop_front();
          s_axis_tdata  <= IN_DATA_W'({cur_req.depth, cur_req.node_b, cur_req.node_a});
          s_axis_tuser  <= cur_req.action;
          s_axis_tlast  <= cur_req.fin;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rcv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lca_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, ancestor %0d last %0b",
                   $time, m_axis_tdata[NODE_W-1:0], m_axis_tlast);
        end else begin
          want = lca_q.pop_front();
          n_answers++;
          if (m_axis_tdata[NODE_W-1:0] !== want.ancestor) begin
            errors++;
            $display("%0t: ancestor mismatch, expected %0d, actual %0d",
                     $time, want.ancestor, m_axis_tdata[NODE_W-1:0]);
          end
          if (m_axis_tlast !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, m_axis_tlast);
          end
        end
      end
      if (rcv_stall > 0) begin
        rcv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rcv_stall = calm ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d answers still pending", $time, lca_q.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_req(input logic [ACT_W-1:0] action, input int a, input int b,
                          input int d, input bit fin);
    lca_req_t req;
    req = '{action, NODE_W'(a), NODE_W'(b), DEP_W'(d), fin};
    req_q.insert(req_q.size(), req);
  endtask

  task automatic add_load(input int a, input int p, input int d);
    push_req(ACT_LOAD, a, p, d, $urandom_range(0, 1));
    if (a != 0) begin
      gen_depth[a] = DEP_W'(d);
      gen_loaded[a] = 1'b1;
      while (loaded_upto < NODES - 1 && gen_loaded[loaded_upto + 1]) loaded_upto++;
    end
  endtask

  task automatic add_build();
    push_req(ACT_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
             $urandom_range(0, 1023), $urandom_range(0, 1));
    if (gen_count > built_upto) built_upto = gen_count;
  endtask

  task automatic add_query(input int a, input int b, input bit fin);
    push_req(ACT_QUERY, a, b, $urandom_range(0, 1023), fin);
  endtask

  // Parent always below the node, so every ancestor chain stays inside loaded rows.
  task automatic add_tree_node(input int n);
    int p;
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (n == 1 || r < 6) p = 0;
    else if (r < 55) p = n - 1;
    else if (r < 85) p = $urandom_range(n - 1, (n > 8) ? n - 8 : 1);
    else p = $urandom_range(n - 1, 1);
    d = (p == 0) ? 0 : int'(gen_depth[p]) + 1;
    if ($urandom_range(0, 15) == 0) d = $urandom_range(0, 1023);
    add_load(n, p, d);
  endtask

  task automatic wait_idle(input int settle);
    while (req_q.size() != 0 || s_axis_tvalid || lca_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic change_count(input int v);
    // the last build may still be running with no result to show for it
    wait_idle(LEVELS * (gen_count + 4) + 64);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CNT_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    node_limit = CNT_W'(v);
    gen_count = v;
    calm = ($urandom_range(0, 3) == 0);
    @(negedge clk_i);
  endtask

  initial begin
    int counts [6];
    int r;
    int a;
    int b;
    foreach (anc_mem[i, k]) anc_mem[i][k] = '0;
    foreach (dep_mem[i]) begin
      dep_mem[i] = '0;
      gen_depth[i] = '0;
      gen_loaded[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: ignored load of node 0, unused action, single-node tree at reset count.
    add_load(0, 1023, 1023);
    push_req(ACT_UNUSED, 1023, 1023, 1023, 1'b1);
    add_load(1, 0, 0);
    add_build();
    add_query(1, 0, 1'b0);
    add_query(0, 0, 1'b0);
    add_query(1, 1, 1'b1);

    // Directed: small forest with a chain, siblings and a second root.
    change_count(10);
    add_load(2, 1, 1);
    add_load(3, 1, 1);
    add_load(4, 2, 2);
    add_load(5, 2, 2);
    add_load(6, 4, 3);
    add_load(7, 6, 4);
    add_load(8, 7, 5);
    add_load(9, 0, 0);
    add_load(10, 9, 1);
    add_load(1023, 1022, 1023);
    add_build();
    add_query(8, 5, 1'b0);
    add_query(7, 3, 1'b0);
    add_query(6, 8, 1'b1);
    add_query(10, 8, 1'b0);
    add_query(0, 4, 1'b1);

    counts = '{$urandom_range(30, 120), $urandom_range(2, 300), 1023,
               $urandom_range(2, 1022), 1, 1023};
    foreach (counts[ph]) begin
      change_count(counts[ph]);
      for (int n = loaded_upto + 1; n <= gen_count; n++) add_tree_node(n);
      add_build();
      repeat (MIX_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          a = $urandom_range(0, built_upto);
          b = $urandom_range(0, built_upto);
          r = $urandom_range(0, 9);
          if (r == 0) b = a;
          else if (r == 1) b = 0;
          else if (r < 5) a = $urandom_range(built_upto, (built_upto > 20) ? built_upto - 20 : 0);
          add_query(a, b, $urandom_range(0, 3) == 0);
        end else if (r < 82) begin
          add_tree_node($urandom_range(1, loaded_upto));
        end else if (r < 86) begin
          add_build();
        end else if (r < 93) begin
          add_load(0, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
          push_req(ACT_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 1023), $urandom_range(0, 1));
        end
      end
    end

    wait_idle(LEVELS * (gen_count + 4) + 64);
    $display("Covered %0d loads, %0d builds, %0d queries, %0d ignored requests;",
             n_loads, n_builds, n_queries, n_ignored);
    $display("%0d answers checked, trees up to node 1023, node_count from 1 to 1023.",
             n_answers);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
design/lcal_pkg.sv
design/lcal_ram.sv
design/lcal_dp.sv
design/lcal_ctrl.sv
design/lowest_common_ancestor_lifting_top.sv
design/lcal_checker.sv
tb/tb_lowest_common_ancestor_lifting_top.sv
